@@ rtl/rced_pkg.sv @@
`timescale 1ns / 1ps

package rced_pkg;

    localparam int PIX_W      = 8;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESHOLD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BINARY_MODE    = 2'd3;

    localparam logic [CFG_DATA_W-1:0] LINE_WIDTH_RST   = 12'd640;
    localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RST = 12'd480;
    localparam logic [PIX_W-1:0]      THRESHOLD_RST    = 8'd30;
    localparam logic                  BINARY_MODE_RST  = 1'b1;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;
    localparam logic [PIX_W-1:0] PIX_MIN = 8'd0;

    // floor(s / 3) as (s * 683) >> 11, exact for s < 2048
    localparam int SUM_W      = PIX_W + 2;
    localparam int PROD_W     = 2 * SUM_W;
    localparam logic [SUM_W-1:0] DIV3_MUL = 10'd683;
    localparam int DIV3_SHIFT = 11;

endpackage

@@ rtl/roberts_cross_edge_detector.sv @@
`timescale 1ns / 1ps

// channel   direction  handshake            payload
// s_        in         s_valid / s_ready    s_red, s_green, s_blue, s_frame_start
// m_        out        m_valid / m_ready    m_out_red, m_out_green, m_out_blue,
//                                           m_edge_flag, m_frame_last
// cfg_      in         cfg_we               cfg_index, cfg_wdata
//
// one pixel per cycle while the output is not stalled; line store read and
// gray are registered at pixel accept, then the magnitude as the result
// the line store has one read and one write port, both used at pixel accept
// reset clears counters, neighbor grays, valids and config registers; the line
// store is not cleared and must be filled by a first row
// a stalled result holds the magnitude stage, which then holds the input

module roberts_cross_edge_detector #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              cfg_we,
    input  logic [rced_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rced_pkg::CFG_DATA_W-1:0]   cfg_wdata,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [rced_pkg::PIX_W-1:0]        s_red,
    input  logic [rced_pkg::PIX_W-1:0]        s_green,
    input  logic [rced_pkg::PIX_W-1:0]        s_blue,
    input  logic                              s_frame_start,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [rced_pkg::PIX_W-1:0]        m_out_red,
    output logic [rced_pkg::PIX_W-1:0]        m_out_green,
    output logic [rced_pkg::PIX_W-1:0]        m_out_blue,
    output logic                              m_edge_flag,
    output logic                              m_frame_last
);

    import rced_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    // configuration
    logic [CFG_DATA_W-1:0] line_width_reg;
    logic [CFG_DATA_W-1:0] frame_height_reg;
    logic [PIX_W-1:0]      threshold_reg;
    logic                  binary_mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg   <= LINE_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            threshold_reg    <= THRESHOLD_RST;
            binary_mode_reg  <= BINARY_MODE_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_LINE_WIDTH:     line_width_reg   <= cfg_wdata;
                REG_FRAME_HEIGHT:   frame_height_reg <= cfg_wdata;
                REG_EDGE_THRESHOLD: threshold_reg    <= cfg_wdata[PIX_W-1:0];
                REG_BINARY_MODE:    binary_mode_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // clamped frame dimensions
    logic [WW-1:0] width_eff;
    logic [HW-1:0] height_eff;

    always_comb begin
        if (line_width_reg < CFG_DATA_W'(2)) begin
            width_eff = WW'(2);
        end else if (32'(line_width_reg) > 32'(MAX_WIDTH)) begin
            width_eff = WW'(MAX_WIDTH);
        end else begin
            width_eff = WW'(line_width_reg);
        end
        if (frame_height_reg < CFG_DATA_W'(2)) begin
            height_eff = HW'(2);
        end else if (32'(frame_height_reg) > 32'(MAX_HEIGHT)) begin
            height_eff = HW'(MAX_HEIGHT);
        end else begin
            height_eff = HW'(frame_height_reg);
        end
    end

    // handshake control
    logic s1_valid_reg;
    logic m_valid_reg;
    logic out_free;
    logic s_accept;
    logic s1_leave;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = !s1_valid_reg || out_free;
    assign s_accept = s_valid && s_ready;
    assign s1_leave = s1_valid_reg && out_free;

    // position and gray at accept
    logic [XW-1:0]     col_reg, col_next, x_cur;
    logic [YW-1:0]     row_reg, row_next, y_cur;
    logic [WW-1:0]     x_inc;
    logic [HW-1:0]     y_inc;
    logic [SUM_W-1:0]  pix_sum;
    logic [PROD_W-1:0] pix_prod;
    logic [PIX_W-1:0]  gray;
    logic              emit;
    logic              last;

    always_comb begin
        x_cur    = s_frame_start ? '0 : col_reg;
        y_cur    = s_frame_start ? '0 : row_reg;
        x_inc    = WW'(x_cur) + WW'(1);
        y_inc    = HW'(y_cur) + HW'(1);
        pix_sum  = SUM_W'(s_red) + SUM_W'(s_green) + SUM_W'(s_blue);
        pix_prod = PROD_W'(pix_sum) * PROD_W'(DIV3_MUL);
        gray     = pix_prod[DIV3_SHIFT +: PIX_W];
        emit     = (x_cur != '0) && (y_cur != '0)
                   && (WW'(x_cur) < width_eff) && (HW'(y_cur) < height_eff);
        last     = (x_inc == width_eff) && (y_inc == height_eff);
        if (x_inc >= width_eff) begin
            col_next = '0;
            row_next = (y_inc >= height_eff) ? '0 : YW'(y_inc);
        end else begin
            col_next = XW'(x_inc);
            row_next = y_cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (s_accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    logic [PIX_W-1:0] above_gray;

    rced_ram #(
        .DATA_W (PIX_W),
        .DEPTH  (MAX_WIDTH)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (s_accept),
        .wr_addr (x_cur),
        .wr_data (gray),
        .rd_en   (s_accept),
        .rd_addr (x_cur),
        .rd_data (above_gray)
    );

    // magnitude stage
    logic [PIX_W-1:0] s1_gray_reg;
    logic             s1_emit_reg;
    logic             s1_last_reg;
    logic [PIX_W-1:0] left_gray_reg;
    logic [PIX_W-1:0] ul_gray_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            left_gray_reg <= '0;
            ul_gray_reg   <= '0;
        end else begin
            if (s_accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_leave) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_leave) begin
                left_gray_reg <= s1_gray_reg;
                ul_gray_reg   <= above_gray;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_gray_reg <= gray;
            s1_emit_reg <= emit;
            s1_last_reg <= last;
        end
    end

    logic [PIX_W-1:0] diff_ad;
    logic [PIX_W-1:0] diff_bc;
    logic [PIX_W:0]   mag_sum;
    logic [PIX_W-1:0] mag;
    logic             is_edge;

    always_comb begin
        diff_ad = (ul_gray_reg >= s1_gray_reg) ? ul_gray_reg - s1_gray_reg
                                               : s1_gray_reg - ul_gray_reg;
        diff_bc = (above_gray >= left_gray_reg) ? above_gray - left_gray_reg
                                                : left_gray_reg - above_gray;
        mag_sum = (PIX_W+1)'(diff_ad) + (PIX_W+1)'(diff_bc);
        mag     = mag_sum[PIX_W] ? PIX_MAX : mag_sum[PIX_W-1:0];
        is_edge = mag > threshold_reg;
    end

    // result register
    logic [PIX_W-1:0] out_red_reg;
    logic [PIX_W-1:0] out_green_reg;
    logic [PIX_W-1:0] out_blue_reg;
    logic             edge_flag_reg;
    logic             frame_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= s1_valid_reg && s1_emit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_leave && s1_emit_reg) begin
            if (binary_mode_reg) begin
                out_red_reg   <= is_edge ? PIX_MAX : PIX_MIN;
                out_green_reg <= PIX_MIN;
                out_blue_reg  <= PIX_MIN;
            end else begin
                out_red_reg   <= mag;
                out_green_reg <= mag;
                out_blue_reg  <= mag;
            end
            edge_flag_reg  <= is_edge;
            frame_last_reg <= s1_last_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_red    = out_red_reg;
    assign m_out_green  = out_green_reg;
    assign m_out_blue   = out_blue_reg;
    assign m_edge_flag  = edge_flag_reg;
    assign m_frame_last = frame_last_reg;

    // checks
    a_stall_holds_above: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !out_free |=> $stable(above_gray))
        else $error("line store data changed under a stalled item");

    a_ready_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> s1_valid_reg && m_valid_reg && !m_ready)
        else $error("input stalled with room in the pipeline");

    a_green_blue_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_out_green == m_out_blue)
        else $error("green and blue of a result differ");

endmodule

@@ rtl/rced_ram.sv @@
`timescale 1ns / 1ps

module rced_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2048
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // read returns the old word on a same-address write
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
